@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Timestamp completion window package
// Shared constants, command codes and word types for the completion window.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// The bitmap is indexed by the low bits of a timestamp, so the window
	// size is a power of two.
	localparam int WINDOW_SIZE = 1024;
	localparam int IDX_W       = $clog2(WINDOW_SIZE);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [31:0] HALF_PLUS_ONE = 32'(WINDOW_SIZE / 2 + 1);
	localparam logic [31:0] QUARTER       = 32'(WINDOW_SIZE / 4);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW_SIZE);

	typedef enum logic [2:0] {
		CMD_MARK  = 3'd0,
		CMD_QUERY = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_SLIDE = 3'd3,
		CMD_INIT  = 3'd4
	} tcw_cmd_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] timestamp;
	} tcw_req_t;

	typedef struct packed {
		logic        completed;
		logic [31:0] window_base;
	} tcw_rsp_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic             wdata;
	} tcw_mem_req_t;

endpackage

@@ hdl/timestamp_completion_window_unit.sv @@
// ----------------------------------------------------------------------------
// Timestamp completion window
// Circular completion bitmap with a sliding window base, one command at a time.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; each command
// gives one result word, shown for a single cycle with done, which the
// receiver must take as it comes. Mark, clear and unknown commands finish in
// the execute state, and a query adds a response state for the registered
// bitmap read. A slide that does not move the window ends at the check; one
// that does computes the target base and the span, then clears the span,
// where span is the number of entries cleared (the whole window, 1024, when
// the move reaches past it). Reinitialise clears the whole bitmap, and after
// reset busy stays high while the bitmap is cleared. The single-port bitmap
// clears one entry per cycle; the slide steps through the one shared subtractor.
module timestamp_completion_window_unit
	import tcw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  tcw_req_t request,
	output logic     busy,
	output logic     done,
	output tcw_rsp_t result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_QRESP,
		ST_CHK,
		ST_TGT,
		ST_SPAN,
		ST_CLEAR
	} state_t;

	state_t           state_q;
	tcw_req_t         req_q;
	tcw_rsp_t         rsp_q;
	logic             done_q;
	logic [31:0]      base_q;
	logic [31:0]      tgt_q;
	logic [32:0]      diff_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ptr_q;
	logic             pend_q;

	logic [31:0]  alu_a;
	logic [31:0]  alu_b;
	logic [32:0]  alu_diff;
	tcw_mem_req_t mem_req;
	logic         rdata;

	tcw_alu u_alu (
		.op_a (alu_a),
		.op_b (alu_b),
		.diff (alu_diff)
	);

	tcw_bitmap u_bitmap (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	always_comb begin
		unique case (state_q)
			ST_CHK: begin
				alu_a = diff_q[31:0];
				alu_b = HALF_PLUS_ONE;
			end
			ST_TGT: begin
				alu_a = req_q.timestamp;
				alu_b = QUARTER;
			end
			ST_SPAN: begin
				alu_a = diff_q[31:0];
				alu_b = QUARTER;
			end
			default: begin
				alu_a = req_q.timestamp;
				alu_b = base_q;
			end
		endcase
	end

	always_comb begin
		mem_req.addr  = (state_q == ST_CLEAR) ? ptr_q : req_q.timestamp[IDX_W-1:0];
		mem_req.wdata = (state_q == ST_EXEC) && (req_q.command == CMD_MARK);
		mem_req.we    = ((state_q == ST_EXEC) &&
				((req_q.command == CMD_MARK) || (req_q.command == CMD_CLEAR))) ||
				((state_q == ST_CLEAR) && (cnt_q != '0));
	end

	// Reset starts in the clearing loop so the bitmap is swept before the
	// first command; pend_q stays low so that sweep produces no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			req_q   <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
			base_q  <= '0;
			tgt_q   <= '0;
			diff_q  <= '0;
			cnt_q   <= FULL_COUNT;
			ptr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= request;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (req_q.command)
						CMD_QUERY: begin
							state_q <= ST_QRESP;
						end
						CMD_SLIDE: begin
							diff_q  <= alu_diff;
							state_q <= ST_CHK;
						end
						CMD_INIT: begin
							cnt_q   <= FULL_COUNT;
							ptr_q   <= '0;
							tgt_q   <= '0;
							pend_q  <= 1'b1;
							state_q <= ST_CLEAR;
						end
						default: begin
							done_q            <= 1'b1;
							rsp_q.completed   <= 1'b0;
							rsp_q.window_base <= base_q;
							state_q           <= ST_IDLE;
						end
					endcase
				end
				ST_QRESP: begin
					done_q            <= 1'b1;
					rsp_q.completed   <= rdata;
					rsp_q.window_base <= base_q;
					state_q           <= ST_IDLE;
				end
				ST_CHK: begin
					// The window moves only when the timestamp is more than
					// half a window past the base.
					if (diff_q[32] || alu_diff[32]) begin
						done_q            <= 1'b1;
						rsp_q.completed   <= 1'b0;
						rsp_q.window_base <= base_q;
						state_q           <= ST_IDLE;
					end else begin
						state_q <= ST_TGT;
					end
				end
				ST_TGT: begin
					tgt_q   <= alu_diff[31:0];
					state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					if (alu_diff[31:IDX_W] != '0) begin
						cnt_q <= FULL_COUNT;
						ptr_q <= '0;
					end else begin
						cnt_q <= {1'b0, alu_diff[IDX_W-1:0]};
						ptr_q <= base_q[IDX_W-1:0];
					end
					pend_q  <= 1'b1;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
						ptr_q <= ptr_q + 1'b1;
					end else begin
						base_q <= tgt_q;
						if (pend_q) begin
							done_q            <= 1'b1;
							rsp_q.completed   <= 1'b0;
							rsp_q.window_base <= tgt_q;
						end
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	// The result strobe drops again after every result; done is never held high.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
	else $error("result strobe held for more than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done_q))
	else $error("accepted command did not occupy the block");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_COUNT)
	else $error("clear count exceeds the window size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.completed) |-> $past(state_q == ST_QRESP))
	else $error("completed flag set on a result that is not a query");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && cnt_q == '0) |=> (base_q == $past(tgt_q)))
	else $error("window base not updated at the end of a clear sweep");

endmodule

@@ hdl/tcw_alu.sv @@
// ----------------------------------------------------------------------------
// Shared subtract unit
// One 33-bit subtractor; the top bit of the difference is the borrow.
// ----------------------------------------------------------------------------
module tcw_alu
	import tcw_pkg::*;
(
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [32:0] diff
);

	assign diff = {1'b0, op_a} - {1'b0, op_b};

endmodule

@@ hdl/tcw_bitmap.sv @@
// ----------------------------------------------------------------------------
// Completion bitmap
// Single-port bit memory with one access per cycle and registered read data.
// ----------------------------------------------------------------------------
module tcw_bitmap
	import tcw_pkg::*;
(
	input  logic         clk,
	input  tcw_mem_req_t mem_req,
	output logic         rdata
);

	logic mem [WINDOW_SIZE];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.addr] <= mem_req.wdata;
		end
		rdata_q <= mem[mem_req.addr];
	end

	assign rdata = rdata_q;

endmodule
